### design/multichannel_frame_fifo_assert.svh
// Assertion helpers used by mff_ctrl. Each expects clk and rst_n in scope.
`ifndef MULTICHANNEL_FRAME_FIFO_ASSERT_SVH
`define MULTICHANNEL_FRAME_FIFO_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MFF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mff_pkg.sv
`default_nettype none

package mff_pkg;

  localparam int MAX_FRAMES   = 1024;
  localparam int MAX_CHANNELS = 4;
  localparam int LANES        = 4;
  localparam int SAMPLE_W     = 16;
  localparam int FRAME_W      = LANES * SAMPLE_W;
  localparam int ADDR_W       = $clog2(MAX_FRAMES);
  localparam int CNT_W        = $clog2(MAX_FRAMES + 1);
  localparam int LANE_CNT_W   = 3;
  localparam int LANE_LIMIT   = (MAX_CHANNELS < LANES) ? MAX_CHANNELS : LANES;

  localparam int REQ_W        = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 11;
  localparam int OUT_DATA_W   = 88;

  localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MARK    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_UNMARK  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_STATUS  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'd1;

  localparam logic [CNT_W-1:0]      CAP_RESET   = CNT_W'(1024);
  localparam logic [LANE_CNT_W-1:0] LANES_RESET = 3'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [FRAME_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_cmd_t;

  typedef struct packed {
    logic                  done;
    logic                  pop_ok;
    logic [LANE_CNT_W-1:0] lanes;
    logic                  last;
    logic [CNT_W-1:0]      stored;
    logic [CNT_W-1:0]      free;
    logic                  eos;
  } res_meta_t;

endpackage

`default_nettype wire

### design/multichannel_frame_fifo.sv
// Multichannel audio frame FIFO.
// Input channel (in_*): one request per transaction. in_tuser carries the
// request code (push, pop, clear, mark end, clear end, status), in_tdata the
// four 16-bit lanes of the frame to push, in_tlast the batch-end mark.
// Output channel (out_*): one result per request. out_tuser is the done bit,
// out_tdata the popped lanes plus frames stored, frames free and end of stream
// after the request, out_tlast the echoed batch-end mark.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle while the receiver keeps taking results;
// the frame RAM takes one write and one registered read per cycle, and the read
// word lands directly in the output register.
// A stalled receiver holds the output register; in_tready stays high only
// while that register is empty or being taken in the same cycle.
// Reset (synchronous, active low) empties the store, clears end of stream and
// sets capacity 1024 and two channels; no clearing pass is needed.
// Configuration writes (cfg_*) also empty the store; issue them while idle.
`default_nettype none

module multichannel_frame_fifo
  import mff_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [FRAME_W-1:0]    in_tdata,   // sample_in_0..sample_in_3
  input  wire logic [REQ_W-1:0]      in_tuser,   // req_type
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // sample_out_0..3, frames_stored,
                                                 // frames_free, end_of_stream, pad
  output logic                       out_tuser,  // done_res
  output logic                       out_tlast
);

  logic               acc;
  logic               out_valid_r, out_valid_nxt;
  ram_cmd_t           ram_cmd;
  res_meta_t          meta_r;
  logic [FRAME_W-1:0] rdata_r;
  logic [FRAME_W-1:0] lanes_out;

  assign in_tready     = !out_valid_r || out_tready;
  assign acc           = in_tvalid && in_tready;
  assign out_valid_nxt = acc || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  mff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .req       (in_tuser),
    .samples   (in_tdata),
    .last      (in_tlast),
    .ram_cmd   (ram_cmd),
    .meta_r    (meta_r)
  );

  mff_frame_ram #(
    .DEPTH  (MAX_FRAMES),
    .WIDTH  (FRAME_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_cmd.we),
    .waddr   (ram_cmd.waddr),
    .wdata   (ram_cmd.wdata),
    .re      (ram_cmd.re),
    .raddr   (ram_cmd.raddr),
    .rdata_r (rdata_r)
  );

  // drop the read word unless this transaction popped a frame, and zero lanes beyond the channel count
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lanes_out[k*SAMPLE_W +: SAMPLE_W] =
        (meta_r.pop_ok && (LANE_CNT_W'(k) < meta_r.lanes)) ?
          rdata_r[k*SAMPLE_W +: SAMPLE_W] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = meta_r.done;
  assign out_tlast  = meta_r.last;
  assign out_tdata  = OUT_DATA_W'({meta_r.eos, meta_r.free, meta_r.stored, lanes_out});

endmodule

`default_nettype wire

### design/mff_frame_ram.sv
`default_nettype none

module mff_frame_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/mff_ctrl.sv
`default_nettype none

`include "multichannel_frame_fifo_assert.svh"

module mff_ctrl
  import mff_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  acc,
  input  wire logic [REQ_W-1:0]      req,
  input  wire logic [FRAME_W-1:0]    samples,
  input  wire logic                  last,
  output ram_cmd_t                   ram_cmd,
  output res_meta_t                  meta_r
);

  logic [CNT_W-1:0]      cap_r, cap_nxt;
  logic [LANE_CNT_W-1:0] lanes_r, lanes_nxt;
  logic [CNT_W-1:0]      held_r, held_nxt;
  logic [ADDR_W-1:0]     rd_r, rd_nxt;
  logic [ADDR_W-1:0]     wr_r, wr_nxt;
  logic                  eos_r, eos_nxt;

  logic                  push_ok, pop_ok, push_go, pop_go;
  logic [CNT_W-1:0]      wr_plus, rd_plus;
  logic [ADDR_W-1:0]     wr_inc, rd_inc;
  logic [CNT_W-1:0]      cap_wr;
  logic [LANE_CNT_W-1:0] lanes_wr;
  logic [FRAME_W-1:0]    wdata;
  res_meta_t             meta_nxt;

  assign push_ok = held_r < cap_r;
  assign pop_ok  = held_r != '0;

  // slots wrap at the capacity in use
  assign wr_plus = CNT_W'({1'b0, wr_r}) + CNT_W'(1);
  assign rd_plus = CNT_W'({1'b0, rd_r}) + CNT_W'(1);
  assign wr_inc  = (wr_plus == cap_r) ? '0 : wr_plus[ADDR_W-1:0];
  assign rd_inc  = (rd_plus == cap_r) ? '0 : rd_plus[ADDR_W-1:0];

  assign cap_wr = (32'(cfg_wdata) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : CNT_W'(cfg_wdata);

  always_comb begin
    lanes_wr = cfg_wdata[LANE_CNT_W-1:0];
    if (lanes_wr == '0) begin
      lanes_wr = LANE_CNT_W'(1);
    end else if (32'(lanes_wr) > LANE_LIMIT) begin
      lanes_wr = LANE_CNT_W'(LANE_LIMIT);
    end
  end

  always_comb begin
    cap_nxt   = cap_r;
    lanes_nxt = lanes_r;
    held_nxt  = held_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    eos_nxt   = eos_r;
    push_go   = 1'b0;
    pop_go    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: cap_nxt   = cap_wr;
        CFG_CHANNELS: lanes_nxt = lanes_wr;
      endcase
      held_nxt = '0;
      rd_nxt   = '0;
      wr_nxt   = '0;
      eos_nxt  = 1'b0;
    end else if (acc) begin
      unique case (req)
        REQ_PUSH: begin
          if (push_ok) begin
            push_go  = 1'b1;
            wr_nxt   = wr_inc;
            held_nxt = held_r + CNT_W'(1);
          end
        end
        REQ_POP: begin
          if (pop_ok) begin
            pop_go   = 1'b1;
            rd_nxt   = rd_inc;
            held_nxt = held_r - CNT_W'(1);
          end
        end
        REQ_CLEAR: begin
          held_nxt = '0;
          rd_nxt   = '0;
          wr_nxt   = '0;
          eos_nxt  = 1'b0;
        end
        REQ_MARK:   eos_nxt = 1'b1;
        REQ_UNMARK: eos_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  // zero the lanes beyond the channel count before storing
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      wdata[k*SAMPLE_W +: SAMPLE_W] =
        (LANE_CNT_W'(k) < lanes_r) ? samples[k*SAMPLE_W +: SAMPLE_W] : '0;
    end
  end

  always_comb begin
    ram_cmd.we    = push_go;
    ram_cmd.waddr = wr_r;
    ram_cmd.wdata = wdata;
    ram_cmd.re    = pop_go;
    ram_cmd.raddr = rd_r;
  end

  always_comb begin
    meta_nxt.done   = push_go | pop_go;
    meta_nxt.pop_ok = pop_go;
    meta_nxt.lanes  = lanes_r;
    meta_nxt.last   = last;
    meta_nxt.stored = held_nxt;
    meta_nxt.free   = cap_r - held_nxt;
    meta_nxt.eos    = eos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      lanes_r <= LANES_RESET;
      held_r  <= '0;
      rd_r    <= '0;
      wr_r    <= '0;
      eos_r   <= 1'b0;
    end else begin
      cap_r   <= cap_nxt;
      lanes_r <= lanes_nxt;
      held_r  <= held_nxt;
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      eos_r   <= eos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      meta_r <= meta_nxt;
    end
  end

  `MFF_ASSERT_IMPL(a_held_bound, 1'b1, held_r <= cap_r, "held count exceeds capacity")
  `MFF_ASSERT_IMPL(a_empty_slots, held_r == '0, rd_r == wr_r, "empty store with split slots")
  `MFF_ASSERT_NEXT(a_push_count, acc && !cfg_we && req == REQ_PUSH && held_r < cap_r,
                   held_r == $past(held_r) + CNT_W'(1), "accepted push did not count")

endmodule

`default_nettype wire
